// ===== rtl/core/pure_pursuit_steering_assert.svh =====
// Assertion macros for the pure pursuit steering RTL.
`ifndef PURE_PURSUIT_STEERING_ASSERT_SVH
`define PURE_PURSUIT_STEERING_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pure pursuit steering assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pure pursuit steering assertion failed");

`endif

// ===== rtl/core/pps_pkg.sv =====
// Types, constants and tables of the pure pursuit steering block.
`timescale 1ns / 1ps
package pps_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COORD_WIDTH_DEF  = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [15:0] SPEED_GO_RST     = 16'd800;
    localparam logic [15:0] SPEED_MIDDLE_RST = 16'd800;
    localparam logic [15:0] SPEED_SLOW_RST   = 16'd650;
    localparam logic [15:0] SPEED_SLOWER_RST = 16'd150;
    localparam logic [15:0] WHEELBASE_RST    = 16'd266;
    localparam logic [7:0]  GAIN_RST         = 8'd51;
    localparam logic [15:0] OFFSET_RST       = 16'd512;
    localparam logic [15:0] WINDOW_RST       = 16'd2560;
    localparam logic [15:0] TARGET_RST       = 16'd300;
    localparam logic [15:0] LOOKAHEAD_RST    = 16'd512;

    typedef enum logic [2:0] {
        REG_SPEED_GO     = 3'd0,
        REG_SPEED_MIDDLE = 3'd1,
        REG_SPEED_SLOW   = 3'd2,
        REG_SPEED_SLOWER = 3'd3,
        REG_WHEELBASE    = 3'd4,
        REG_GAIN         = 3'd5,
        REG_OFFSET       = 3'd6,
        REG_WINDOW       = 3'd7
    } t_reg_index;

    localparam logic       KIND_STATUS = 1'b0;
    localparam logic       KIND_POINT  = 1'b1;
    localparam logic [1:0] MAP_GO       = 2'd0;
    localparam logic [1:0] MAP_SLOW     = 2'd1;
    localparam logic [1:0] MAP_OVERTAKE = 2'd2;
    localparam logic [1:0] MAP_UNKNOWN  = 2'd3;
    localparam logic [2:0] CAR_GO       = 3'd0;
    localparam logic [2:0] CAR_CAUTION  = 3'd1;
    localparam logic [2:0] CAR_STOP     = 3'd2;
    localparam logic [2:0] CAR_LANE     = 3'd3;
    localparam logic [2:0] CAR_UNKNOWN  = 3'd4;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] speed_now;
        logic        [1:0]  map_mode;
        logic        [2:0]  car_mode;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic        [15:0] cmd_speed;
        logic signed [15:0] steer_angle;
        logic               found;
        logic        [15:0] lookahead_used;
    } t_out_item;

    typedef struct packed {
        logic [15:0] speed_go;
        logic [15:0] speed_middle;
        logic [15:0] speed_slow;
        logic [15:0] speed_slower;
        logic [15:0] wheelbase;
        logic [7:0]  gain;
        logic [15:0] offset;
        logic [15:0] window;
    } t_cfg;

    typedef enum logic [1:0] {F_IDLE, F_CALC, F_DECIDE} t_front_state;
    typedef enum logic [2:0] {B_IDLE, B_SQRT, B_MUL, B_CORDIC, B_OUT} t_back_state;

    // Floor of atan(2^-i) in units of 2^-30 rad.
    function automatic logic signed [31:0] atan_tab(input logic [4:0] i);
        logic signed [31:0] v;
        unique case (i)
            5'd0:  v = 32'sd843314856;
            5'd1:  v = 32'sd497837829;
            5'd2:  v = 32'sd263043836;
            5'd3:  v = 32'sd133525158;
            5'd4:  v = 32'sd67021686;
            5'd5:  v = 32'sd33543515;
            5'd6:  v = 32'sd16775850;
            5'd7:  v = 32'sd8388437;
            5'd8:  v = 32'sd4194282;
            5'd9:  v = 32'sd2097149;
            5'd10: v = 32'sd1048575;
            5'd11: v = 32'sd524287;
            5'd12: v = 32'sd262143;
            5'd13: v = 32'sd131071;
            5'd14: v = 32'sd65535;
            5'd15: v = 32'sd32767;
            5'd16: v = 32'sd16383;
            5'd17: v = 32'sd8191;
            5'd18: v = 32'sd4095;
            5'd19: v = 32'sd2047;
            5'd20: v = 32'sd1023;
            5'd21: v = 32'sd511;
            5'd22: v = 32'sd255;
            5'd23: v = 32'sd127;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/pps_front.sv =====
// Front part: takes items, updates mode state and runs the look-ahead window test.
`timescale 1ns / 1ps
module pps_front #(
    parameter int COORD_WIDTH = pps_pkg::COORD_WIDTH_DEF,
    localparam int D2W  = 2 * COORD_WIDTH + 1,
    localparam int JW   = 1 + 16 + 16 + COORD_WIDTH + D2W,
    localparam int CMPW = (D2W > 34) ? D2W : 34
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pps_pkg::t_in_item i_in_data,
    input  pps_pkg::t_cfg     i_cfg,
    output logic              o_push,
    output logic [JW-1:0]     o_job,
    input  logic              i_full
);

    pps_pkg::t_front_state r_state, n_state;
    pps_pkg::t_in_item     r_item;
    logic signed [24:0]    r_prod;
    logic [D2W-1:0]        r_d2;
    logic [31:0]           r_lo;
    logic [33:0]           r_hi;
    logic [15:0]           r_target;
    logic [15:0]           r_ld;
    logic                  r_found;

    logic signed [COORD_WIDTH-1:0] px, py;
    logic [2*COORD_WIDTH-1:0]      sx, sy;
    logic signed [8:0]             gain_s;
    logic [16:0]                   ld_win;
    logic signed [25:0]            ld_sum;
    logic [15:0]                   ld_new;
    logic [15:0]                   tgt_new;
    logic                          hit;
    logic                          need_push;

    generate
        if (COORD_WIDTH <= 16) begin : g_narrow
            assign px = r_item.point_x[COORD_WIDTH-1:0];
            assign py = r_item.point_y[COORD_WIDTH-1:0];
        end else begin : g_wide
            assign px = {{(COORD_WIDTH-16){1'b0}}, r_item.point_x};
            assign py = {{(COORD_WIDTH-16){1'b0}}, r_item.point_y};
        end
    endgenerate

    assign sx     = px * px;
    assign sy     = py * py;
    assign gain_s = {1'b0, i_cfg.gain};
    assign ld_win = {1'b0, r_ld} + {1'b0, i_cfg.window};
    assign ld_sum = (r_prod >>> 8) + $signed({10'b0, i_cfg.offset});

    always_comb begin
        if (ld_sum < 0) begin
            ld_new = 16'd0;
        end else if (ld_sum > 26'sd65535) begin
            ld_new = 16'hFFFF;
        end else begin
            ld_new = ld_sum[15:0];
        end
    end

    // An unknown map or car mode leaves the target speed alone.
    always_comb begin
        tgt_new = r_target;
        if (r_item.map_mode != pps_pkg::MAP_UNKNOWN) begin
            unique case (r_item.car_mode)
                pps_pkg::CAR_GO: begin
                    unique case (r_item.map_mode)
                        pps_pkg::MAP_GO:       tgt_new = i_cfg.speed_go;
                        pps_pkg::MAP_SLOW:     tgt_new = i_cfg.speed_slow;
                        pps_pkg::MAP_OVERTAKE: tgt_new = i_cfg.speed_middle;
                        default:               tgt_new = r_target;
                    endcase
                end
                pps_pkg::CAR_CAUTION: begin
                    tgt_new = (r_item.map_mode == pps_pkg::MAP_SLOW) ?
                              i_cfg.speed_slower : i_cfg.speed_slow;
                end
                pps_pkg::CAR_STOP: tgt_new = 16'd0;
                pps_pkg::CAR_LANE: tgt_new = i_cfg.speed_slow;
                default:           tgt_new = r_target;
            endcase
        end
    end

    assign hit = (CMPW'(r_lo) <= CMPW'(r_d2)) && (CMPW'(r_d2) < CMPW'(r_hi));
    assign need_push = (r_item.kind == pps_pkg::KIND_POINT) && !r_found &&
                       (hit || r_item.last);
    assign o_job = {hit, r_target, r_ld, py, r_d2};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pps_pkg::F_IDLE:   if (i_in_valid) n_state = pps_pkg::F_CALC;
            pps_pkg::F_CALC:   n_state = pps_pkg::F_DECIDE;
            pps_pkg::F_DECIDE: if (!(need_push && i_full)) n_state = pps_pkg::F_IDLE;
            default:           n_state = pps_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == pps_pkg::F_IDLE);
        o_push     = (r_state == pps_pkg::F_DECIDE) && need_push && !i_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pps_pkg::F_IDLE;
            r_target <= pps_pkg::TARGET_RST;
            r_ld     <= pps_pkg::LOOKAHEAD_RST;
            r_found  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pps_pkg::F_DECIDE) begin
                if (r_item.kind == pps_pkg::KIND_STATUS) begin
                    r_target <= tgt_new;
                    r_ld     <= ld_new;
                    r_found  <= 1'b0;
                end else if (o_push && hit) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_in_data;
        end
        if (r_state == pps_pkg::F_CALC) begin
            r_prod <= gain_s * r_item.speed_now;
            r_d2   <= {1'b0, sx} + {1'b0, sy};
            r_lo   <= r_ld * r_ld;
            r_hi   <= ld_win * ld_win;
        end
    end

endmodule

// ===== rtl/core/pps_queue.sv =====
// Short job queue between the front and back parts.
`timescale 1ns / 1ps
`include "pure_pursuit_steering_assert.svh"
module pps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pps_pkg::QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `PPS_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `PPS_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty)
    `PPS_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

// ===== rtl/core/pps_back.sv =====
// Back part: square root, CORDIC steering angle and the result register.
`timescale 1ns / 1ps
module pps_back #(
    parameter int COORD_WIDTH  = pps_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = pps_pkg::CORDIC_STEPS_DEF,
    localparam int D2W = 2 * COORD_WIDTH + 1,
    localparam int JW  = 1 + 16 + 16 + COORD_WIDTH + D2W,
    localparam int SQW = 2 * COORD_WIDTH + 2,
    localparam int SCW = $clog2(COORD_WIDTH + 2),
    localparam int IW  = $clog2(CORDIC_STEPS),
    localparam int XW  = COORD_WIDTH + 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  logic [JW-1:0]      i_job,
    output logic               o_pop,
    input  logic [15:0]        i_wheelbase,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pps_pkg::t_out_item o_out_data
);

    pps_pkg::t_back_state r_state, n_state;
    logic                          r_hit;
    logic [15:0]                   r_target, r_ld;
    logic signed [COORD_WIDTH-1:0] r_y;
    logic [SQW-1:0]                r_rem, r_res, r_bit;
    logic [SCW-1:0]                r_scnt;
    logic signed [XW-1:0]          r_cx, r_cy;
    logic signed [31:0]            r_z;
    logic [IW-1:0]                 r_i;
    logic                          r_out_valid;
    pps_pkg::t_out_item            r_out;

    logic [SQW-1:0]                trial;
    logic signed [XW-1:0]          xs, ys;
    logic signed [32:0]            z_round;
    logic signed [15:0]            steer;
    logic                          out_free;
    logic                          sqrt_done, cordic_done, zero_vec;
    logic [16+COORD_WIDTH:0]       prod_x;
    logic signed [18+COORD_WIDTH-1:0] prod_y;
    logic signed [17:0]            wb2;

    assign trial    = r_res + r_bit;
    assign xs       = r_cx >>> r_i;
    assign ys       = r_cy >>> r_i;
    assign wb2      = {1'b0, i_wheelbase, 1'b0};
    assign prod_x   = r_ld * r_res[COORD_WIDTH:0];
    assign prod_y   = wb2 * r_y;
    assign z_round  = (33'(r_z) + 33'sd65536) >>> 17;
    assign steer    = -z_round[15:0];
    assign out_free = !r_out_valid || i_out_ready;
    assign sqrt_done   = (r_scnt == SCW'(COORD_WIDTH));
    assign cordic_done = (r_i == IW'(CORDIC_STEPS - 1));
    assign zero_vec    = (r_i == '0) && (r_cx == '0) && (r_cy == '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pps_pkg::B_IDLE: begin
                if (!i_empty) begin
                    n_state = i_job[JW-1] ? pps_pkg::B_SQRT : pps_pkg::B_OUT;
                end
            end
            pps_pkg::B_SQRT:   if (sqrt_done) n_state = pps_pkg::B_MUL;
            pps_pkg::B_MUL:    n_state = pps_pkg::B_CORDIC;
            pps_pkg::B_CORDIC: if (cordic_done || zero_vec) n_state = pps_pkg::B_OUT;
            pps_pkg::B_OUT:    if (out_free) n_state = pps_pkg::B_IDLE;
            default:           n_state = pps_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = (r_state == pps_pkg::B_IDLE) && !i_empty;
        o_out_valid = r_out_valid;
        o_out_data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pps_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pps_pkg::B_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pps_pkg::B_IDLE: begin
                r_hit    <= i_job[JW-1];
                r_target <= i_job[JW-2 -: 16];
                r_ld     <= i_job[JW-18 -: 16];
                r_y      <= i_job[D2W +: COORD_WIDTH];
                r_rem    <= SQW'(i_job[D2W-1:0]);
                r_res    <= '0;
                r_bit    <= SQW'(1) << (SQW - 2);
                r_scnt   <= '0;
                r_z      <= '0;
                r_i      <= '0;
            end
            pps_pkg::B_SQRT: begin
                // One result bit per beat of the digit-by-digit root.
                if (r_rem >= trial) begin
                    r_rem <= r_rem - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_scnt <= r_scnt + 1'b1;
            end
            pps_pkg::B_MUL: begin
                r_cx <= $signed(XW'(prod_x));
                r_cy <= XW'(prod_y);
            end
            pps_pkg::B_CORDIC: begin
                if (!zero_vec) begin
                    if (r_cy > 0) begin
                        r_cx <= r_cx + ys;
                        r_cy <= r_cy - xs;
                        r_z  <= r_z + pps_pkg::atan_tab(5'(r_i));
                    end else begin
                        r_cx <= r_cx - ys;
                        r_cy <= r_cy + xs;
                        r_z  <= r_z - pps_pkg::atan_tab(5'(r_i));
                    end
                    r_i <= r_i + 1'b1;
                end
            end
            pps_pkg::B_OUT: begin
                if (out_free) begin
                    r_out.cmd_speed      <= r_hit ? r_target : 16'd0;
                    r_out.steer_angle    <= r_hit ? steer : 16'sd0;
                    r_out.found          <= r_hit;
                    r_out.lookahead_used <= r_ld;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/pure_pursuit_steering.sv =====
// Pure pursuit steering: the front part takes an item through IDLE, CALC and DECIDE
// (window test or status). A hit runs root, multiply and CORDIC states in the back part:
// one root bit and one CORDIC rotation per cycle; a miss command goes straight to output.
// A two-entry job queue lets the front keep taking points while a steering job runs.
// Synchronous active-low reset restores the state, configuration and control registers.
`timescale 1ns / 1ps
module pure_pursuit_steering #(
    parameter int CORDIC_STEPS = pps_pkg::CORDIC_STEPS_DEF,
    parameter int COORD_WIDTH  = pps_pkg::COORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pps_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pps_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int JW = 1 + 16 + 16 + COORD_WIDTH + 2 * COORD_WIDTH + 1;

    pps_pkg::t_cfg r_cfg;
    logic          push, pop, full, empty;
    logic [JW-1:0] job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_go     <= pps_pkg::SPEED_GO_RST;
            r_cfg.speed_middle <= pps_pkg::SPEED_MIDDLE_RST;
            r_cfg.speed_slow   <= pps_pkg::SPEED_SLOW_RST;
            r_cfg.speed_slower <= pps_pkg::SPEED_SLOWER_RST;
            r_cfg.wheelbase    <= pps_pkg::WHEELBASE_RST;
            r_cfg.gain         <= pps_pkg::GAIN_RST;
            r_cfg.offset       <= pps_pkg::OFFSET_RST;
            r_cfg.window       <= pps_pkg::WINDOW_RST;
        end else if (i_cfg_we) begin
            unique case (pps_pkg::t_reg_index'(i_cfg_index))
                pps_pkg::REG_SPEED_GO:     r_cfg.speed_go     <= i_cfg_data;
                pps_pkg::REG_SPEED_MIDDLE: r_cfg.speed_middle <= i_cfg_data;
                pps_pkg::REG_SPEED_SLOW:   r_cfg.speed_slow   <= i_cfg_data;
                pps_pkg::REG_SPEED_SLOWER: r_cfg.speed_slower <= i_cfg_data;
                pps_pkg::REG_WHEELBASE:    r_cfg.wheelbase    <= i_cfg_data;
                pps_pkg::REG_GAIN:         r_cfg.gain         <= i_cfg_data[7:0];
                pps_pkg::REG_OFFSET:       r_cfg.offset       <= i_cfg_data;
                pps_pkg::REG_WINDOW:       r_cfg.window       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pps_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .o_push     (push),
        .o_job      (job_in),
        .i_full     (full)
    );

    pps_queue #(.WIDTH(JW), .DEPTH(pps_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_empty (empty)
    );

    pps_back #(.COORD_WIDTH(COORD_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (job_out),
        .o_pop       (pop),
        .i_wheelbase (r_cfg.wheelbase),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
